// ----- rtl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants and control/status types for the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REM     = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

  // Controller -> datapath
  typedef struct packed {
    logic capture;    // latch the incoming token
    logic latch_err;  // record the error found while decoding
    logic push;       // push the operand
    logic rd_issue;   // read the left operand from the stack memory
    logic alu_load;   // load add/sub/mul result
    logic div_start;  // start the divider
    logic div_load;   // load signed quotient or remainder
    logic wb;         // replace the two operands with the result
    logic emit;       // load the output word and clear the expression
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic err_active;
    logic dec_err;
    logic is_operand;
    logic is_divrem;
    logic last;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/postfix_stack_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Evaluates a tokenized postfix integer expression on a bounded value stack.
//
//   Channel  Direction  Handshake               Word
//   in       input      in_valid_i/in_ready_o   kind_i, operand_value_i, last_token_i
//   out      output     out_valid_o/out_ready_i result_value_o, status_o
//
// An operand or an erroring or ignored token passes idle, decode and end;
// operators add read and write back, and divide and remainder also wait on
// the divider, which produces one quotient bit per cycle. The stack top is a
// register; deeper values sit in a memory with a registered read port.
// Reset clears the stack count and latched error; the memory is not cleared.
// A pending result word does not block input; only the next last token waits
// for it to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [pse_pkg::KIND_W-1:0]           kind_i,
  input  wire logic signed [pse_pkg::DATA_W-1:0]    operand_value_i,
  input  wire logic                                 last_token_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [pse_pkg::DATA_W-1:0]         result_value_o,
  output logic [pse_pkg::STATUS_W-1:0]              status_o
);

  pse_pkg::cmd_t cmd;
  pse_pkg::sts_t sts;

  pse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .operand_value_i (operand_value_i),
    .last_token_i    (last_token_i),
    .result_value_o  (result_value_o),
    .status_o        (status_o)
  );

endmodule

`default_nettype wire

// ----- rtl/pse_div.sv -----
// ----------------------------------------------------------------------------
// pse_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pse_pkg::DATA_W-1:0]  dividend_i,
  input  wire logic [pse_pkg::DATA_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [pse_pkg::DATA_W-1:0]       quot_o,
  output logic [pse_pkg::DATA_W-1:0]       rem_o
);

  localparam int unsigned DW = pse_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(DW);

  logic [DW-1:0]    quot_q, quot_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  always_comb begin
    trial = {rem_q, quot_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    if (!diff[DW]) begin
      rem_d = diff[DW-1:0];
      quot_d = {quot_q[DW-2:0], 1'b1};
    end else begin
      rem_d = trial[DW-1:0];
      quot_d = {quot_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/pse_datapath.sv -----
// ----------------------------------------------------------------------------
// pse_datapath
// Token latch, value stack (top in a register, rest in memory), ALU,
// divider and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_datapath #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pse_pkg::cmd_t                 cmd_i,
  output pse_pkg::sts_t                      sts_o,
  input  wire logic [pse_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [pse_pkg::DATA_W-1:0] operand_value_i,
  input  wire logic                          last_token_i,
  output logic signed [pse_pkg::DATA_W-1:0]  result_value_o,
  output logic [pse_pkg::STATUS_W-1:0]       status_o
);

  localparam int unsigned DW = pse_pkg::DATA_W;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [pse_pkg::KIND_W-1:0]   kind_q;
  logic [DW-1:0]                val_q;
  logic                         last_q;
  logic [CW-1:0]                count_q;
  logic [pse_pkg::STATUS_W-1:0] err_q;
  logic [DW-1:0]                top_q;
  logic [DW-1:0]                rd_q;
  logic [DW-1:0]                res_q;
  logic [DW-1:0]                mem_q [STACK_DEPTH];
  logic [DW-1:0]                out_value_q;
  logic [pse_pkg::STATUS_W-1:0] out_status_q;

  logic [CW-1:0]                cnt_m1;
  logic [CW-1:0]                cnt_m2;
  logic [pse_pkg::STATUS_W-1:0] dec_code;
  logic [pse_pkg::STATUS_W-1:0] fin_status;
  logic                         is_divrem;
  logic                         na, nb;
  logic [DW-1:0]                ua, ub;
  logic                         div_done;
  logic [DW-1:0]                div_quot, div_rem;
  logic [DW-1:0]                alu_res;
  logic [DW-1:0]                div_res;

  assign cnt_m1    = count_q - CW'(1);
  assign cnt_m2    = count_q - CW'(2);
  assign is_divrem = (kind_q == pse_pkg::KIND_DIV) || (kind_q == pse_pkg::KIND_REM);

  // Error this token would raise, if any
  always_comb begin
    case (kind_q) inside
      pse_pkg::KIND_OPERAND: begin
        dec_code = (count_q == CW'(STACK_DEPTH)) ? pse_pkg::ST_OVERFLOW : pse_pkg::ST_OK;
      end
      [pse_pkg::KIND_ADD:pse_pkg::KIND_REM]: begin
        if (count_q < CW'(2)) begin
          dec_code = pse_pkg::ST_UNDERFLOW;
        end else if (is_divrem && top_q == '0) begin
          dec_code = pse_pkg::ST_DIVZERO;
        end else begin
          dec_code = pse_pkg::ST_OK;
        end
      end
      default: dec_code = pse_pkg::ST_INVALID;
    endcase
  end

  always_comb begin
    if (err_q != pse_pkg::ST_OK) begin
      fin_status = err_q;
    end else if (count_q == '0) begin
      fin_status = pse_pkg::ST_UNDERFLOW;
    end else if (count_q != CW'(1)) begin
      fin_status = pse_pkg::ST_LEFTOVER;
    end else begin
      fin_status = pse_pkg::ST_OK;
    end
  end

  // Left operand comes from memory, right operand is the top register
  assign na = rd_q[DW-1];
  assign nb = top_q[DW-1];
  assign ua = na ? (DW'(0) - rd_q) : rd_q;
  assign ub = nb ? (DW'(0) - top_q) : top_q;

  always_comb begin
    case (kind_q)
      pse_pkg::KIND_ADD: alu_res = rd_q + top_q;
      pse_pkg::KIND_SUB: alu_res = rd_q - top_q;
      default:           alu_res = rd_q * top_q;
    endcase
  end

  always_comb begin
    if (kind_q == pse_pkg::KIND_DIV) begin
      div_res = (na != nb) ? (DW'(0) - div_quot) : div_quot;
    end else begin
      div_res = na ? (DW'(0) - div_rem) : div_rem;
    end
  end

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ua),
    .divisor_i  (ub),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= pse_pkg::ST_OK;
    end else begin
      if (cmd_i.latch_err) begin
        err_q <= dec_code;
      end
      if (cmd_i.push) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.wb) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.emit) begin
        count_q <= '0;
        err_q   <= pse_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      val_q  <= operand_value_i;
      last_q <= last_token_i;
    end
    if (cmd_i.push) begin
      top_q <= val_q;
    end
    if (cmd_i.wb) begin
      top_q <= res_q;
    end
    if (cmd_i.alu_load) begin
      res_q <= alu_res;
    end
    if (cmd_i.div_load) begin
      res_q <= div_res;
    end
    if (cmd_i.emit) begin
      out_value_q  <= (fin_status == pse_pkg::ST_OK) ? top_q : '0;
      out_status_q <= fin_status;
    end
  end

  // Values below the top live in memory; spill the old top on a push
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && count_q != '0) begin
      mem_q[cnt_m1[AW-1:0]] <= top_q;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[cnt_m2[AW-1:0]];
    end
  end

  assign sts_o.err_active = (err_q != pse_pkg::ST_OK);
  assign sts_o.dec_err    = (dec_code != pse_pkg::ST_OK);
  assign sts_o.is_operand = (kind_q == pse_pkg::KIND_OPERAND);
  assign sts_o.is_divrem  = is_divrem;
  assign sts_o.last       = last_q;
  assign sts_o.div_done   = div_done;

  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/pse_ctrl.sv -----
// ----------------------------------------------------------------------------
// pse_ctrl
// Token sequencer: decode, operand read, execute, write back, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire pse_pkg::sts_t sts_i,
  output pse_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_DIV,
    S_WB,
    S_END
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.err_active) begin
          state_d = S_END;
        end else if (sts_i.dec_err) begin
          cmd_o.latch_err = 1'b1;
          state_d = S_END;
        end else if (sts_i.is_operand) begin
          cmd_o.push = 1'b1;
          state_d = S_END;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.is_divrem) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.alu_load = 1'b1;
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_load = 1'b1;
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d = S_END;
      end
      S_END: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          // hold until the previous result word is taken
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !out_ready_i) || cmd_o.emit;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
